// ----- src/iee_pkg.sv -----
// shared types and constants for the infix expression evaluator
`default_nettype none
package iee_pkg;
  localparam int StackDepth = 64;
  localparam int PtrW = $clog2(StackDepth);
  localparam int CntW = $clog2(StackDepth + 1);
  localparam int ValW = 32;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3, OP_MOD = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0, ERR_DIV0 = 2'd1, ERR_OVF = 2'd2, ERR_MISSING = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    PH_EXPECT = 2'd0, PH_NUMBER = 2'd1, PH_AFTER = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PUSHNUM, S_RLOOK, S_RPOPB, S_RPOPA, S_RCALC, S_RDIV,
    S_RPUSH, S_PUSHOP, S_ENDCHK, S_FINAL, S_OUT
  } state_t;
endpackage
`default_nettype wire

// ----- src/infix_expression_evaluator_core.sv -----
// infix expression evaluator top level: scanner, two stacks and a shared alu
// sequencing: a plain character is taken while idle; an operator or the final
// character also pushes the pending number and runs each reduction through the
// stack ports, with a divide or modulo using the shared one-bit-per-cycle divider.
// throughput: one character at a time, not ready until the previous is done.
// reset: synchronous active-low rst_n clears state, counts, accumulator, phase and error latch.
`default_nettype none
module infix_expression_evaluator_core import iee_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_char_code,
  input  wire logic        in_end_of_expr,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [31:0] out_value,
  output logic [1:0]       out_error_code
);
  logic [ValW-1:0] opnd_mem [StackDepth];
  logic [2:0]      oper_mem [StackDepth];

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  err_t   err_r, err_nxt;
  logic [CntW-1:0] ocnt_r, ocnt_nxt, pcnt_r, pcnt_nxt;
  logic [ValW-1:0] acc_r, acc_nxt, a_r, a_nxt, b_r, b_nxt, res_r, res_nxt;
  logic [2:0] op_r, op_nxt, newop_r, newop_nxt;
  logic end_r, end_nxt, isend_r, isend_nxt;
  logic [ValW-1:0] rd_opnd_r;
  logic [2:0] rd_oper_r;
  // divider
  logic [ValW-1:0] quo_r, quo_nxt, rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [5:0] dcnt_r, dcnt_nxt;
  logic [ValW-1:0] outv_r, outv_nxt;
  logic [1:0] oute_r, oute_nxt;

  logic opnd_we, oper_we;
  logic [PtrW-1:0] opnd_wa, oper_wa, opnd_ra, oper_ra;
  logic [ValW-1:0] opnd_wd;
  logic [2:0] oper_wd;

  logic in_acc;
  logic [7:0] ch;
  logic is_dig, is_op;
  logic [2:0] opc;
  logic [ValW-1:0] dig, mb, rtry;
  logic [ValW:0] rsh;

  assign in_acc = in_valid && !in_stall;
  assign ch = in_char_code;
  assign is_dig = ch >= 8'h30 && ch <= 8'h39;
  assign dig = ValW'(ch - 8'h30);
  assign mb = b_r[ValW-1] ? -b_r : b_r;
  assign rsh = {rem_r, quo_r[ValW-1]};
  assign rtry = rsh[ValW-1:0] - dvs_r;

  always_comb begin
    is_op = 1'b1;
    opc = OP_ADD;
    case (ch)
      8'h2b: opc = OP_ADD;
      8'h2d: opc = OP_SUB;
      8'h2a: opc = OP_MUL;
      8'h2f: opc = OP_DIV;
      8'h25: opc = OP_MOD;
      default: is_op = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (opnd_we) opnd_mem[opnd_wa] <= opnd_wd;
    if (oper_we) oper_mem[oper_wa] <= oper_wd;
    rd_opnd_r <= opnd_mem[opnd_ra];
    rd_oper_r <= oper_mem[oper_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_EXPECT;
      err_r <= ERR_NONE;
      ocnt_r <= '0;
      pcnt_r <= '0;
      acc_r <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      err_r <= err_nxt;
      ocnt_r <= ocnt_nxt;
      pcnt_r <= pcnt_nxt;
      acc_r <= acc_nxt;
    end
    a_r <= a_nxt; b_r <= b_nxt; res_r <= res_nxt; op_r <= op_nxt;
    newop_r <= newop_nxt; end_r <= end_nxt; isend_r <= isend_nxt;
    quo_r <= quo_nxt; rem_r <= rem_nxt; dvs_r <= dvs_nxt; dcnt_r <= dcnt_nxt;
    outv_r <= outv_nxt; oute_r <= oute_nxt;
  end

  always_comb begin
    state_nxt = state_r; phase_nxt = phase_r; err_nxt = err_r;
    ocnt_nxt = ocnt_r; pcnt_nxt = pcnt_r; acc_nxt = acc_r;
    a_nxt = a_r; b_nxt = b_r; res_nxt = res_r; op_nxt = op_r;
    newop_nxt = newop_r; end_nxt = end_r; isend_nxt = isend_r;
    quo_nxt = quo_r; rem_nxt = rem_r; dvs_nxt = dvs_r; dcnt_nxt = dcnt_r;
    outv_nxt = outv_r; oute_nxt = oute_r;
    opnd_we = 1'b0; oper_we = 1'b0;
    opnd_wa = ocnt_r[PtrW-1:0]; oper_wa = pcnt_r[PtrW-1:0];
    opnd_wd = acc_r; oper_wd = newop_r;
    opnd_ra = ocnt_r[PtrW-1:0] - 1'b1;
    oper_ra = pcnt_r[PtrW-1:0] - 1'b1;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_acc) begin
          end_nxt = in_end_of_expr;
          isend_nxt = 1'b0;
          newop_nxt = opc;
          state_nxt = in_end_of_expr ? S_ENDCHK : S_IDLE;
          if (err_r == ERR_NONE) begin
            case (phase_r)
              PH_EXPECT: if (is_dig) begin
                acc_nxt = dig;
                phase_nxt = PH_NUMBER;
              end
              PH_NUMBER: begin
                if (is_dig) acc_nxt = (acc_r << 3) + (acc_r << 1) + dig;
                else begin
                  phase_nxt = is_op ? PH_EXPECT : PH_AFTER;
                  isend_nxt = is_op;
                  state_nxt = S_PUSHNUM;
                end
              end
              default: if (is_op) begin
                phase_nxt = PH_EXPECT;
                isend_nxt = 1'b1;
                state_nxt = S_RLOOK;
              end
            endcase
          end
        end
      end
      S_PUSHNUM: begin
        // isend_r here flags an operator to handle afterward
        if (ocnt_r == CntW'(StackDepth)) err_nxt = ERR_OVF;
        else begin
          opnd_we = 1'b1;
          ocnt_nxt = ocnt_r + 1'b1;
        end
        acc_nxt = '0;
        if (ocnt_r == CntW'(StackDepth)) state_nxt = end_r ? S_ENDCHK : S_IDLE;
        else if (isend_r) state_nxt = S_RLOOK;
        else state_nxt = end_r ? S_ENDCHK : S_IDLE;
      end
      S_RLOOK: begin
        // operator read address settles; data arrives next cycle
        state_nxt = S_RPOPB;
        opnd_ra = ocnt_r[PtrW-1:0] - 1'b1;
      end
      S_RPOPB: begin
        // isend_r set: reduce on operator; end_r and !isend_r: drain at end
        if (err_r != ERR_NONE) state_nxt = end_r ? S_FINAL : S_IDLE;
        else if (pcnt_r == '0 ||
                 (isend_r && newop_r >= OP_MUL && rd_oper_r < OP_MUL)) begin
          state_nxt = isend_r ? S_PUSHOP : S_FINAL;
        end else if (ocnt_r < CntW'(2)) begin
          err_nxt = ERR_MISSING;
          state_nxt = end_r ? S_FINAL : S_IDLE;
        end else begin
          op_nxt = rd_oper_r;
          b_nxt = rd_opnd_r;
          opnd_ra = ocnt_r[PtrW-1:0] - 2'd2;
          state_nxt = S_RPOPA;
        end
      end
      S_RPOPA: begin
        opnd_ra = ocnt_r[PtrW-1:0] - 2'd2;
        state_nxt = S_RCALC;
      end
      S_RCALC: begin
        a_nxt = rd_opnd_r;
        ocnt_nxt = ocnt_r - 2'd2;
        pcnt_nxt = pcnt_r - 1'b1;
        state_nxt = S_RPUSH;
        case (op_r)
          OP_ADD: res_nxt = rd_opnd_r + b_r;
          OP_SUB: res_nxt = rd_opnd_r - b_r;
          OP_MUL: res_nxt = rd_opnd_r * b_r;
          default: begin
            if (b_r == '0) begin
              err_nxt = ERR_DIV0;
              state_nxt = end_r ? S_FINAL : S_IDLE;
            end else state_nxt = S_RDIV;
            dcnt_nxt = '0;
            quo_nxt = rd_opnd_r[ValW-1] ? -rd_opnd_r : rd_opnd_r;
            rem_nxt = '0;
            dvs_nxt = mb;
          end
        endcase
      end
      S_RDIV: begin
        // restoring divide, one quotient bit a cycle
        if (rsh[ValW] || rsh[ValW-1:0] >= dvs_r) begin
          rem_nxt = rtry;
          quo_nxt = {quo_r[ValW-2:0], 1'b1};
        end else begin
          rem_nxt = rsh[ValW-1:0];
          quo_nxt = {quo_r[ValW-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == 6'(ValW - 1)) begin
          state_nxt = S_RPUSH;
          if (op_r == OP_DIV)
            res_nxt = (a_r[ValW-1] ^ b_r[ValW-1]) ? -quo_nxt : quo_nxt;
          else res_nxt = a_r[ValW-1] ? -rem_nxt : rem_nxt;
        end
      end
      S_RPUSH: begin
        opnd_we = 1'b1;
        opnd_wd = res_r;
        ocnt_nxt = ocnt_r + 1'b1;
        state_nxt = S_RLOOK;
      end
      S_PUSHOP: begin
        if (pcnt_r == CntW'(StackDepth)) err_nxt = ERR_OVF;
        else begin
          oper_we = 1'b1;
          pcnt_nxt = pcnt_r + 1'b1;
        end
        state_nxt = end_r ? S_ENDCHK : S_IDLE;
      end
      S_ENDCHK: begin
        isend_nxt = 1'b0;
        if (err_r != ERR_NONE) state_nxt = S_FINAL;
        else if (phase_r == PH_NUMBER) begin
          phase_nxt = PH_AFTER;
          state_nxt = S_PUSHNUM;
        end else if (phase_r == PH_EXPECT) begin
          err_nxt = ERR_MISSING;
          state_nxt = S_FINAL;
        end else state_nxt = S_RLOOK;
      end
      S_FINAL: begin
        if (err_r == ERR_NONE && ocnt_r == '0) begin
          outv_nxt = '0;
          oute_nxt = ERR_MISSING;
        end else begin
          outv_nxt = (err_r == ERR_NONE) ? rd_opnd_r : '0;
          oute_nxt = err_r;
        end
        ocnt_nxt = '0; pcnt_nxt = '0; acc_nxt = '0;
        phase_nxt = PH_EXPECT; err_nxt = ERR_NONE;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_value = outv_r;
  assign out_error_code = oute_r;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= CntW'(StackDepth) && pcnt_r <= CntW'(StackDepth))
    else $error("stack count out of range");
  a_out_err_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != ERR_NONE |-> out_value == '0)
    else $error("nonzero value with error");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while result pending");
`endif
endmodule
`default_nettype wire

// ----- tb/sv/tb_infix_expression_evaluator_core.sv -----
// self-checking testbench for the infix expression evaluator core
module tb_infix_expression_evaluator_core import iee_pkg::*; ();

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } word_t;

  typedef struct packed {
    logic [31:0] value;
    err_t        err;
  } answer_t;

  localparam int IdleLimit = 20000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [7:0] in_char_code;
  logic in_end_of_expr;
  logic out_valid;
  logic out_stall;
  logic signed [31:0] out_value;
  logic [1:0] out_error_code;

  infix_expression_evaluator_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_char_code(in_char_code), .in_end_of_expr(in_end_of_expr),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_value(out_value), .out_error_code(out_error_code)
  );

  word_t   char_queue[$];
  answer_t answer_queue[$];
  int      fail_count;
  int      idle_cycles;
  bit      stim_done;

  // evaluator state kept by the predictor
  logic [31:0] opnd_stk[StackDepth];
  op_t         oper_stk[StackDepth];
  int          opnd_cnt, oper_cnt;
  logic [31:0] accum;
  phase_t      phase;
  err_t        err_lat;

  function automatic void clear_eval();
    opnd_cnt = 0;
    oper_cnt = 0;
    accum = '0;
    phase = PH_EXPECT;
    err_lat = ERR_NONE;
  endfunction

  function automatic void flag(err_t e);
    if (err_lat == ERR_NONE) err_lat = e;
  endfunction

  function automatic void push_num(logic [31:0] v);
    if (err_lat != ERR_NONE) return;
    if (opnd_cnt >= StackDepth) begin
      flag(ERR_OVF);
      return;
    end
    opnd_stk[opnd_cnt] = v;
    opnd_cnt++;
  endfunction

  function automatic void reduce_top();
    logic signed [31:0] a, b;
    logic [31:0] r;
    op_t o;
    if (opnd_cnt < 2 || oper_cnt == 0) begin
      flag(ERR_MISSING);
      return;
    end
    b = opnd_stk[opnd_cnt - 1];
    a = opnd_stk[opnd_cnt - 2];
    opnd_cnt -= 2;
    oper_cnt--;
    o = oper_stk[oper_cnt];
    r = '0;
    case (o)
      OP_ADD: r = a + b;
      OP_SUB: r = a - b;
      OP_MUL: r = a * b;
      default: begin
        if (b == 0) begin
          flag(ERR_DIV0);
          return;
        end
        // most negative over minus one wraps
        if (a == 32'sh8000_0000 && b == -1) r = (o == OP_DIV) ? a : '0;
        else r = (o == OP_DIV) ? a / b : a % b;
      end
    endcase
    push_num(r);
  endfunction

  function automatic void take_operator(op_t o);
    while (err_lat == ERR_NONE && oper_cnt > 0 &&
           !(o >= OP_MUL && oper_stk[oper_cnt - 1] < OP_MUL))
      reduce_top();
    if (err_lat != ERR_NONE) return;
    if (oper_cnt >= StackDepth) begin
      flag(ERR_OVF);
      return;
    end
    oper_stk[oper_cnt] = o;
    oper_cnt++;
  endfunction

  function automatic int op_of(logic [7:0] c);
    case (c)
      "+": return OP_ADD;
      "-": return OP_SUB;
      "*": return OP_MUL;
      "/": return OP_DIV;
      "%": return OP_MOD;
      default: return -1;
    endcase
  endfunction

  function automatic void eval_char(word_t w);
    bit dig;
    int oc;
    answer_t ans;
    dig = w.ch >= "0" && w.ch <= "9";
    oc = op_of(w.ch);
    if (err_lat == ERR_NONE) begin
      if (phase == PH_EXPECT) begin
        if (dig) begin
          accum = w.ch - "0";
          phase = PH_NUMBER;
        end
      end else if (phase == PH_NUMBER) begin
        if (dig) accum = accum * 10 + (w.ch - "0");
        else begin
          push_num(accum);
          accum = '0;
          if (oc >= 0) begin
            take_operator(op_t'(oc));
            phase = PH_EXPECT;
          end else phase = PH_AFTER;
        end
      end else if (oc >= 0) begin
        take_operator(op_t'(oc));
        phase = PH_EXPECT;
      end
    end
    if (!w.last) return;
    if (err_lat == ERR_NONE) begin
      if (phase == PH_NUMBER) push_num(accum);
      else if (phase == PH_EXPECT) flag(ERR_MISSING);
      while (err_lat == ERR_NONE && oper_cnt > 0) reduce_top();
      if (err_lat == ERR_NONE && opnd_cnt == 0) flag(ERR_MISSING);
    end
    ans.value = (err_lat == ERR_NONE) ? opnd_stk[opnd_cnt - 1] : '0;
    ans.err = err_lat;
    answer_queue.push_back(ans);
    clear_eval();
  endfunction

  // ---- stimulus building ----
  function automatic void put(logic [7:0] c, bit last = 0);
    word_t w;
    w.ch = c;
    w.last = last;
    char_queue.push_back(w);
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) put(s[i], i == s.len() - 1);
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 4))
      0: return "+";
      1: return "-";
      2: return "*";
      3: return "/";
      default: return "%";
    endcase
  endfunction

  function automatic void put_number();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 3);
    for (int i = 0; i < n; i++) put(8'("0" + $urandom_range(0, 9)));
  endfunction

  // well-formed expression with occasional junk, mostly short
  function automatic void put_expr();
    int terms;
    terms = $urandom_range(1, 6);
    for (int t = 0; t < terms; t++) begin
      if ($urandom_range(0, 7) == 0) put(" ");
      put_number();
      if ($urandom_range(0, 7) == 0) put(8'($urandom_range(0, 255)));
      if (t != terms - 1) put(rand_op());
    end
    char_queue[$].last = 1;
  endfunction

  initial begin
    string s;
    clear_eval();
    // directed
    put_str("");
    put(" ", 1);
    put_str("2147483647+1");
    put_str("4294967295");
    put_str("7-3*2");
    put_str("100/7%4");
    put_str("7/0");
    put_str("5%0");
    put_str("2147483648/4294967295");
    put_str("2147483648%4294967295");
    put_str("0-7/2");
    put_str("0-7%2");
    put_str("12 34+1");
    put_str("3+*4");
    put_str("9-");
    put(8'hff);
    put("5", 1);
    // overflow of the operand stack is unreachable; operator stack would need
    // 64 pending low ops under high ones, which left association prevents
    s = "";
    for (int i = 0; i < 70; i++) s = {s, "1+"};
    put_str({s, "1"});
    // random
    while (char_queue.size() < 950) begin
      if ($urandom_range(0, 9) == 0) begin
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) put(8'($urandom_range(0, 255)), i == n - 1);
      end else put_expr();
    end
    stim_done = 1;
  end

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
  end

  // driver: bursts and gaps
  int burst_left, gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      in_char_code <= '0;
      in_end_of_expr <= 0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (in_valid && in_stall) begin
      // hold the word
    end else if (gap_left > 0) begin
      in_valid <= 0;
      gap_left <= gap_left - 1;
    end else if (char_queue.size() > 0) begin
      word_t w;
      w = char_queue.pop_front();
      eval_char(w);
      in_valid <= 1;
      in_char_code <= w.ch;
      in_end_of_expr <= w.last;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 30);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end else burst_left <= burst_left - 1;
    end else in_valid <= 0;
  end

  // receiver stall pattern, with one long hold-off early on
  int rx_cycle;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
      rx_cycle <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle > 200 && rx_cycle < 1500) out_stall <= 1;
      else if (rx_cycle % 4000 < 1000) out_stall <= 0;
      else out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (answer_queue.size() == 0) begin
        $display("%0t unexpected result value=%0d err=%0d", $time, out_value,
                 out_error_code);
        fail_count++;
      end else begin
        answer_t e;
        e = answer_queue.pop_front();
        if (out_value !== e.value)
          $display("%0t value mismatch exp=%0d got=%0d", $time,
                   $signed(e.value), out_value);
        if (out_error_code !== e.err)
          $display("%0t error code mismatch exp=%0d got=%0d", $time, e.err,
                   out_error_code);
        if (out_value !== e.value || out_error_code !== e.err) fail_count++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    wait (char_queue.size() == 0 && !(in_valid && in_stall));
    wait (answer_queue.size() == 0);
    repeat (3000) @(posedge clk);
    if (fail_count == 0 && answer_queue.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
